### rtl/hcl_pkg.sv
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared types and constants of the class-loader payload blocker.
// ----------------------------------------------------------------------------
package hcl_pkg;

  // Packet limits and scan window
  localparam int SCAN_LIMIT   = 384;
  localparam int MATCH_WINDOW = 30;
  localparam int MAX_PACKET   = 65535;

  // Byte position counter
  localparam int POS_W = 16;

  // Header constants
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] IP_MIN_HDR  = 8'd20;
  localparam logic [7:0] TCP_MIN_HDR = 8'd20;

  // Watched destination ports
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;
  localparam logic [15:0] PORT_HTTPS_ALT = 16'd8443;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_ADDR_W-1:0] CFG_RULE_ENABLE   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_OFFSET = 1'b1;
  localparam logic [5:0] HEADER_OFFSET_RST = 6'd14;

  // Verdict reason codes
  localparam logic [2:0] REASON_MATCH      = 3'd0;
  localparam logic [2:0] REASON_TOO_SHORT  = 3'd1;
  localparam logic [2:0] REASON_NOT_TCP    = 3'd2;
  localparam logic [2:0] REASON_UNWATCHED  = 3'd3;
  localparam logic [2:0] REASON_RULE_OFF   = 3'd4;
  localparam logic [2:0] REASON_NO_PAYLOAD = 3'd5;
  localparam logic [2:0] REASON_NO_MATCH   = 3'd6;

  // Queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       pkt_last;
  } in_word_t;

  typedef struct packed {
    logic        drop;
    logic [2:0]  reason;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } out_word_t;

  // Word passed from the parser to the matcher
  typedef struct packed {
    logic [7:0]  pkt_byte;
    logic        last;
    logic        scan_ok;   // window start lies in the scanned payload range
    logic [2:0]  reason;    // pre-verdict, valid on last
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } mid_word_t;

  // Previous bytes of the packet, oldest first
  typedef logic [7:0] hist_t [MATCH_WINDOW-1];

endpackage

### rtl/hcl_front.sv
// ----------------------------------------------------------------------------
// hcl_front
// Byte parser: tracks position, pulls IPv4/TCP header fields, flags scan
// positions and builds the pre-verdict on the last byte of a packet.
// ----------------------------------------------------------------------------
module hcl_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hcl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hcl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            take,
  input  hcl_pkg::in_word_t               in_word,
  output hcl_pkg::mid_word_t              mid_word
);
  import hcl_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET);
  localparam logic [POS_W-1:0] WIN_LAG   = POS_W'(MATCH_WINDOW - 1);
  localparam logic [POS_W-1:0] SCAN_SPAN = POS_W'(SCAN_LIMIT - MATCH_WINDOW);

  // Configuration registers
  logic       rule_enable;
  logic [5:0] header_offset;

  // Per-packet parse state
  logic [POS_W-1:0] pos;
  logic [5:0]       ip_hdr_bytes;
  logic [7:0]       proto;
  logic [5:0]       tcp_hdr_bytes;
  logic [15:0]      tcp_sport;
  logic [15:0]      tcp_dport;

  logic             active;
  logic [POS_W-1:0] h16;
  logic [5:0]       ip_hdr_bytes_next;
  logic [7:0]       proto_next;
  logic [5:0]       tcp_hdr_bytes_next;
  logic [15:0]      tcp_sport_next;
  logic [15:0]      tcp_dport_next;
  logic [6:0]       tcp_start;
  logic [POS_W-1:0] t16;
  logic [7:0]       pay_start;
  logic [POS_W-1:0] p16;
  logic [POS_W-1:0] win_start;
  logic [POS_W-1:0] pos_next;
  logic             watched;
  logic [2:0]       reason;

  // Header field capture for the current byte
  always_comb begin
    active             = (pos != POS_MAX);
    h16                = {{(POS_W-6){1'b0}}, header_offset};
    ip_hdr_bytes_next  = ip_hdr_bytes;
    proto_next         = proto;
    tcp_sport_next     = tcp_sport;
    tcp_dport_next     = tcp_dport;
    tcp_hdr_bytes_next = tcp_hdr_bytes;
    if (active && pos == h16) begin
      ip_hdr_bytes_next = {in_word.pkt_byte[3:0], 2'b00};
    end
    if (active && pos == h16 + POS_W'(9)) begin
      proto_next = in_word.pkt_byte;
    end
    tcp_start = {1'b0, header_offset} + {1'b0, ip_hdr_bytes_next};
    t16       = {{(POS_W-7){1'b0}}, tcp_start};
    if (active && pos == t16) begin
      tcp_sport_next[15:8] = in_word.pkt_byte;
    end
    if (active && pos == t16 + POS_W'(1)) begin
      tcp_sport_next[7:0] = in_word.pkt_byte;
    end
    if (active && pos == t16 + POS_W'(2)) begin
      tcp_dport_next[15:8] = in_word.pkt_byte;
    end
    if (active && pos == t16 + POS_W'(3)) begin
      tcp_dport_next[7:0] = in_word.pkt_byte;
    end
    if (active && pos == t16 + POS_W'(12)) begin
      tcp_hdr_bytes_next = {in_word.pkt_byte[7:4], 2'b00};
    end
    pay_start = {1'b0, tcp_start} + {2'b00, tcp_hdr_bytes_next};
    p16       = {{(POS_W-8){1'b0}}, pay_start};
    win_start = pos - WIN_LAG;
    pos_next  = active ? pos + POS_W'(1) : pos;
  end

  // Pre-verdict; a clean packet is marked no-match until the matcher says otherwise
  always_comb begin
    watched = (tcp_dport_next == PORT_HTTP) || (tcp_dport_next == PORT_HTTP_ALT) ||
              (tcp_dport_next == PORT_HTTPS) || (tcp_dport_next == PORT_HTTPS_ALT);
    if (pos_next < h16 + POS_W'(IP_MIN_HDR)) begin
      reason = REASON_TOO_SHORT;
    end else if (proto_next != PROTO_TCP) begin
      reason = REASON_NOT_TCP;
    end else if (pos_next < t16 + POS_W'(TCP_MIN_HDR)) begin
      reason = REASON_TOO_SHORT;
    end else if (!watched) begin
      reason = REASON_UNWATCHED;
    end else if (!rule_enable) begin
      reason = REASON_RULE_OFF;
    end else if (pos_next <= p16) begin
      reason = REASON_NO_PAYLOAD;
    end else begin
      reason = REASON_NO_MATCH;
    end
  end

  // Word toward the matcher
  always_comb begin
    mid_word.pkt_byte = in_word.pkt_byte;
    mid_word.last     = in_word.pkt_last;
    mid_word.scan_ok  = active && (pos >= WIN_LAG) && (win_start >= p16) &&
                        ((win_start - p16) < SCAN_SPAN);
    mid_word.reason   = reason;
    if (reason == REASON_TOO_SHORT || reason == REASON_NOT_TCP) begin
      mid_word.source_port = '0;
      mid_word.dest_port   = '0;
    end else begin
      mid_word.source_port = tcp_sport_next;
      mid_word.dest_port   = tcp_dport_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_enable   <= 1'b0;
      header_offset <= HEADER_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RULE_ENABLE:   rule_enable   <= cfg_wdata[0];
        CFG_HEADER_OFFSET: header_offset <= cfg_wdata;
      endcase
    end
  end

  // Parse state: advances per byte, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      ip_hdr_bytes  <= '0;
      proto         <= '0;
      tcp_hdr_bytes <= '0;
      tcp_sport     <= '0;
      tcp_dport     <= '0;
    end else if (take) begin
      if (in_word.pkt_last) begin
        pos           <= '0;
        ip_hdr_bytes  <= '0;
        proto         <= '0;
        tcp_hdr_bytes <= '0;
        tcp_sport     <= '0;
        tcp_dport     <= '0;
      end else begin
        pos           <= pos_next;
        ip_hdr_bytes  <= ip_hdr_bytes_next;
        proto         <= proto_next;
        tcp_hdr_bytes <= tcp_hdr_bytes_next;
        tcp_sport     <= tcp_sport_next;
        tcp_dport     <= tcp_dport_next;
      end
    end
  end

  // A new packet starts at position zero
  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    take && in_word.pkt_last |=> pos == '0)
    else $error("position not cleared after last byte");

endmodule

### rtl/hcl_mid_fifo.sv
// ----------------------------------------------------------------------------
// hcl_mid_fifo
// Short queue between the parser and the matcher.
// ----------------------------------------------------------------------------
module hcl_mid_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  hcl_pkg::mid_word_t wr_word,
  input  logic               rd,
  output hcl_pkg::mid_word_t rd_word,
  output logic               full,
  output logic               empty
);
  import hcl_pkg::*;

  localparam int PTR_W = $clog2(MID_DEPTH);
  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  mid_word_t          mem [MID_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cnt;

  assign full    = (cnt == CNT_W'(MID_DEPTH));
  assign empty   = (cnt == '0);
  assign rd_word = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        cnt <= cnt + CNT_W'(1);
      end else if (rd && !wr) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd && empty))
    else $error("read from empty queue");

endmodule

### rtl/hcl_back.sv
// ----------------------------------------------------------------------------
// hcl_back
// Pattern matcher over the byte history, final verdict and result queue.
// ----------------------------------------------------------------------------
module hcl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                mid_valid,
  input  hcl_pkg::mid_word_t  mid_word,
  output logic                mid_take,
  input  logic                pop,
  output logic                empty,
  output hcl_pkg::out_word_t  out_word
);
  import hcl_pkg::*;

  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int HIST_N = MATCH_WINDOW - 1;

  function automatic logic either_case(input logic [7:0] b, input logic [7:0] lo);
    return (b == lo) || (b == lo - 8'd32);
  endfunction

  // Three binding patterns, anchored at the oldest history byte
  function automatic logic window_hits(input hist_t w);
    logic head;
    logic long_form;
    logic bracket_form;
    logic escape_form;
    head = (w[2] == "a") && (w[3] == "s") && (w[4] == "s");
    long_form = head && either_case(w[0], "c") && either_case(w[1], "l") &&
      (w[5] == ".") && either_case(w[6], "m") && (w[7] == "o") &&
      (w[8] == "d") && (w[9] == "u") && (w[10] == "l") && (w[11] == "e") &&
      (w[12] == ".") && either_case(w[13], "c") && either_case(w[14], "l") &&
      (w[15] == "a") && (w[16] == "s") && (w[17] == "s") &&
      either_case(w[18], "l") && (w[19] == "o") && (w[20] == "a") &&
      (w[21] == "d") && (w[22] == "e") && (w[23] == "r");
    bracket_form = (w[5] == "[") && (w[6] == "m") && (w[7] == "o");
    escape_form  = (w[5] == "%") && (w[6] == "2") && either_case(w[7], "e") &&
                   (w[8] == "m") && (w[9] == "o");
    return long_form ||
           (head && (w[0] == "c") && (w[1] == "l") && (bracket_form || escape_form));
  endfunction

  hist_t            hist;
  logic             match_seen;
  logic             hit;
  logic             seen_any;
  out_word_t        result;
  logic             res_push;
  logic             res_pop;
  out_word_t        mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  // A last byte needs room in the result queue
  assign mid_take = mid_valid && (!mid_word.last || cnt != CNT_W'(OUT_DEPTH));
  assign res_push = mid_take && mid_word.last;
  assign res_pop  = pop && !empty;
  assign empty    = (cnt == '0);
  assign out_word = mem[rd_ptr];

  // Match test and final verdict
  always_comb begin
    hit                = mid_word.scan_ok && window_hits(hist);
    seen_any           = match_seen || hit;
    result.drop        = 1'b0;
    result.reason      = mid_word.reason;
    result.source_port = mid_word.source_port;
    result.dest_port   = mid_word.dest_port;
    if (mid_word.reason == REASON_NO_MATCH && seen_any) begin
      result.drop   = 1'b1;
      result.reason = REASON_MATCH;
    end
  end

  // Byte history shift line
  always_ff @(posedge clk) begin
    if (mid_take) begin
      for (int k = 0; k < HIST_N - 1; k++) begin
        hist[k] <= hist[k+1];
      end
      hist[HIST_N-1] <= mid_word.pkt_byte;
    end
  end

  // Sticky match flag per packet
  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen <= 1'b0;
    end else if (mid_take) begin
      match_seen <= mid_word.last ? 1'b0 : seen_any;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      mem[wr_ptr] <= result;
    end
  end

  // Result queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (res_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (res_push && !res_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (res_pop && !res_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(OUT_DEPTH))
    else $error("result queue count out of range");

  a_drop_reason: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_word.drop == (out_word.reason == REASON_MATCH)))
    else $error("drop flag disagrees with reason");

  a_seen_cleared: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !match_seen)
    else $error("match flag carried into next packet");

endmodule

### rtl/http_class_loader_payload_blocker.sv
// ----------------------------------------------------------------------------
// http_class_loader_payload_blocker
// Drops TCP packets to web ports whose payload carries a class-loader binding.
// ----------------------------------------------------------------------------
//  channel | handshake        | word
//  --------+------------------+-----------------------------------------------
//  input   | push / full      | in_word  : pkt_byte, pkt_last
//  result  | pop / empty      | out_word : drop, reason, source_port, dest_port
//  config  | cfg_we           | cfg_addr, cfg_wdata (0 rule_enable, 1 offset)
//
//  One byte per cycle sustained while full is low; the parser takes a byte every
//  cycle full is low. A verdict reaches the result side through the
//  parser-to-matcher queue and the result queue after the last byte. Reset (rst,
//  synchronous) clears all control state; no memory sweep. A stalled result side
//  fills the result queue, then the parser-to-matcher queue, and only then raises full.
// ----------------------------------------------------------------------------
module http_class_loader_payload_blocker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hcl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hcl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            push,
  output logic                            full,
  input  hcl_pkg::in_word_t               in_word,
  output logic                            empty,
  input  logic                            pop,
  output hcl_pkg::out_word_t              out_word
);
  import hcl_pkg::*;

  mid_word_t front_word;
  mid_word_t queue_word;
  logic      take;
  logic      queue_empty;
  logic      queue_rd;

  assign take = push && !full;

  // Parser
  hcl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .in_word   (in_word),
    .mid_word  (front_word)
  );

  // Decoupling queue
  hcl_mid_fifo u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_word (front_word),
    .rd      (queue_rd),
    .rd_word (queue_word),
    .full    (full),
    .empty   (queue_empty)
  );

  // Matcher and result queue
  hcl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (!queue_empty),
    .mid_word  (queue_word),
    .mid_take  (queue_rd),
    .pop       (pop),
    .empty     (empty),
    .out_word  (out_word)
  );

endmodule
